>>> src/lmdd_pkg.sv
// shared constants for the lock manager with wait-for deadlock detection
// no dependencies; used by lock_manager_deadlock_detect
package lmdd_pkg;

  // default sizes handed to the top level
  localparam int CLIENTS_DEF = 16;
  localparam int LOCKS_DEF   = 16;

  // most results reported for one input word
  localparam int MAX_RESULTS = 16;

  // port field widths
  localparam int ID_W     = 4;
  localparam int STATUS_W = 2;

  // action codes
  localparam logic ACT_LOCK    = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // reply status codes
  localparam logic [STATUS_W-1:0] ST_GRANTED     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_GRANTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OWN_IT      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_PREVENTED   = 2'd3;

endpackage

>>> src/lmdd_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module lmdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/lock_manager_deadlock_detect.sv
// lock manager top level: request sequencer, lock and wait tables, reply output
// depends on lmdd_pkg and lmdd_ram
//
// A word is taken when start is high and busy is low; busy stays high until the
// final reply of that word is issued, and that reply is on the ports in the first
// cycle with busy low. Replies appear one per cycle at most, each for
// exactly one cycle with out_valid high, and must be taken there: the receiver
// cannot stall them; out_last marks the final reply of a word. A lock request
// grants a free lock at once, else reads its owner and, if it has to wait,
// walks the wait chain step by step. A release visits every lock in turn,
// reads the owner of each held lock and, per lock held by the requester,
// sweeps the wait table through its single read port one entry a cycle to
// find the next owner and redirect waiters. Out-of-range requesters, and
// out-of-range locks in lock words, give no reply and leave busy low.
module lock_manager_deadlock_detect #(
  parameter int CLIENTS = lmdd_pkg::CLIENTS_DEF,
  parameter int LOCKS   = lmdd_pkg::LOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [lmdd_pkg::ID_W-1:0]     in_requester,
  input  logic [lmdd_pkg::ID_W-1:0]     in_lock_id,
  output logic                          out_valid,
  output logic [lmdd_pkg::ID_W-1:0]     out_recipient,
  output logic [lmdd_pkg::STATUS_W-1:0] out_status,
  output logic [lmdd_pkg::ID_W-1:0]     out_holder,
  output logic                          out_livelock,
  output logic                          out_last
);

  import lmdd_pkg::*;

  // index widths
  localparam int CIW = $clog2(CLIENTS);
  localparam int CCW = $clog2(CLIENTS + 1);
  localparam int LIW = (LOCKS > 1) ? $clog2(LOCKS) : 1;
  localparam int LCW = $clog2(LOCKS + 1);
  localparam int WW  = CIW + LIW;
  localparam int NW  = $clog2(MAX_RESULTS + 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_REQ      = 9'b000000010,
    S_REQ_OWN  = 9'b000000100,
    S_WALK     = 9'b000001000,
    S_WALK_D   = 9'b000010000,
    S_REL_LOCK = 9'b000100000,
    S_REL_OWN  = 9'b001000000,
    S_SCAN     = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // control registers
  logic [LOCKS-1:0]   held_r, held_nxt;
  logic [CLIENTS-1:0] wvalid_r, wvalid_nxt;
  logic [CIW-1:0]     q_r, q_nxt;
  logic [LIW-1:0]     lk_r, lk_nxt;
  logic [LCW-1:0]     i_r, i_nxt;
  logic [CCW-1:0]     j_r, j_nxt;
  logic [CIW-1:0]     jd_r, jd_nxt;
  logic               rdv_r, rdv_nxt;
  logic               found_r, found_nxt;
  logic [CIW-1:0]     w_r, w_nxt;
  logic [CIW-1:0]     v_r, v_nxt;
  logic [NW-1:0]      cnt_r, cnt_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload registers
  logic [CIW-1:0]      pend_rcpt_r, pend_rcpt_nxt;
  logic [STATUS_W-1:0] pend_status_r, pend_status_nxt;
  logic [CIW-1:0]      pend_holder_r, pend_holder_nxt;
  logic                pend_live_r, pend_live_nxt;
  logic [ID_W-1:0]     out_rcpt_r, out_rcpt_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]     out_holder_r, out_holder_nxt;
  logic                out_live_r, out_live_nxt;
  logic                out_last_r, out_last_nxt;

  // memory ports
  logic           own_we;
  logic [LIW-1:0] own_waddr, own_raddr;
  logic [CIW-1:0] own_wdata, own_rdata;
  logic           wait_we;
  logic [CIW-1:0] wait_waddr, wait_raddr;
  logic [WW-1:0]  wait_wdata, wait_rdata;

  // reply request from the sequencer
  logic                emit_en;
  logic [CIW-1:0]      emit_rcpt;
  logic [STATUS_W-1:0] emit_status;
  logic [CIW-1:0]      emit_holder;
  logic                emit_live;

  logic [LIW-1:0] i_idx;
  logic [CIW-1:0] j_idx;
  logic [CIW-1:0] wt_target;
  logic [LIW-1:0] wt_lock;

  assign i_idx     = i_r[LIW-1:0];
  assign j_idx     = j_r[CIW-1:0];
  assign wt_target = wait_rdata[WW-1:LIW];
  assign wt_lock   = wait_rdata[LIW-1:0];

  // lock owner table
  lmdd_ram #(.WIDTH(CIW), .DEPTH(LOCKS), .AW(LIW)) u_owner_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (own_wdata),
    .raddr (own_raddr),
    .rdata (own_rdata)
  );

  // wait edge table: {target client, lock waited for}
  lmdd_ram #(.WIDTH(WW), .DEPTH(CLIENTS), .AW(CIW)) u_wait_ram (
    .clk   (clk),
    .we    (wait_we),
    .waddr (wait_waddr),
    .wdata (wait_wdata),
    .raddr (wait_raddr),
    .rdata (wait_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    held_nxt    = held_r;
    wvalid_nxt  = wvalid_r;
    q_nxt       = q_r;
    lk_nxt      = lk_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    jd_nxt      = jd_r;
    rdv_nxt     = rdv_r;
    found_nxt   = found_r;
    w_nxt       = w_r;
    v_nxt       = v_r;
    own_we      = 1'b0;
    own_waddr   = lk_r;
    own_wdata   = q_r;
    own_raddr   = lk_r;
    wait_we     = 1'b0;
    wait_waddr  = q_r;
    wait_wdata  = {own_rdata, lk_r};
    wait_raddr  = v_r;
    emit_en     = 1'b0;
    emit_rcpt   = q_r;
    emit_status = ST_GRANTED;
    emit_holder = '0;
    emit_live   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start && (32'(in_requester) < CLIENTS)) begin
          q_nxt = CIW'(in_requester);
          if (in_action == ACT_RELEASE) begin
            i_nxt     = '0;
            state_nxt = S_REL_LOCK;
          end else if (32'(in_lock_id) < LOCKS) begin
            lk_nxt    = LIW'(in_lock_id);
            state_nxt = S_REQ;
          end
        end
      end

      // free lock is granted at once, else look up its owner
      S_REQ: begin
        if (!held_r[lk_r]) begin
          held_nxt[lk_r] = 1'b1;
          own_we         = 1'b1;
          emit_en        = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_REQ_OWN;
        end
      end

      // own it already, or record the wait edge and start the walk
      S_REQ_OWN: begin
        emit_en = 1'b1;
        if (own_rdata == q_r) begin
          emit_status = ST_OWN_IT;
          state_nxt   = S_DONE;
        end else begin
          wait_we          = 1'b1;
          wvalid_nxt[q_r]  = 1'b1;
          emit_status      = ST_NOT_GRANTED;
          emit_holder      = own_rdata;
          v_nxt            = own_rdata;
          state_nxt        = S_WALK;
        end
      end

      // follow the chain from the owner; a path back to the requester is a cycle
      S_WALK: begin
        if (!wvalid_r[v_r]) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_WALK_D;
        end
      end

      S_WALK_D: begin
        if (wt_target == q_r) begin
          wvalid_nxt[q_r] = 1'b0;
          emit_en         = 1'b1;
          emit_status     = ST_PREVENTED;
          emit_live       = &held_r;
          state_nxt       = S_DONE;
        end else begin
          v_nxt     = wt_target;
          state_nxt = S_WALK;
        end
      end

      // release: visit each held lock
      S_REL_LOCK: begin
        own_raddr = i_idx;
        if (i_r == LCW'(LOCKS)) begin
          state_nxt = S_DONE;
        end else if (!held_r[i_idx]) begin
          i_nxt = i_r + 1'b1;
        end else begin
          state_nxt = S_REL_OWN;
        end
      end

      S_REL_OWN: begin
        if (own_rdata == q_r) begin
          j_nxt     = '0;
          rdv_nxt   = 1'b0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_REL_LOCK;
        end
      end

      // sweep the wait table: first waiter takes the lock, later ones are redirected
      S_SCAN: begin
        wait_raddr = j_idx;
        if (j_r != CCW'(CLIENTS)) begin
          jd_nxt  = j_idx;
          rdv_nxt = 1'b1;
          j_nxt   = j_r + 1'b1;
        end else begin
          rdv_nxt = 1'b0;
        end
        if (rdv_r && wvalid_r[jd_r] && (wt_lock == i_idx)) begin
          if (!found_r) begin
            found_nxt        = 1'b1;
            w_nxt            = jd_r;
            wvalid_nxt[jd_r] = 1'b0;
            own_we           = 1'b1;
            own_waddr        = i_idx;
            own_wdata        = jd_r;
            emit_en          = 1'b1;
            emit_rcpt        = jd_r;
          end else begin
            wait_we    = 1'b1;
            wait_waddr = jd_r;
            wait_wdata = {w_r, i_idx};
          end
        end
        if ((j_r == CCW'(CLIENTS)) && !rdv_r) begin
          if (!found_r) begin
            held_nxt[i_idx] = 1'b0;
          end
          i_nxt     = i_r + 1'b1;
          state_nxt = S_REL_LOCK;
        end
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // reply buffer: one reply is held back so the final one can carry last
  always_comb begin
    cnt_nxt         = cnt_r;
    pend_v_nxt      = pend_v_r;
    pend_rcpt_nxt   = pend_rcpt_r;
    pend_status_nxt = pend_status_r;
    pend_holder_nxt = pend_holder_r;
    pend_live_nxt   = pend_live_r;
    out_valid_nxt   = 1'b0;
    out_rcpt_nxt    = ID_W'(pend_rcpt_r);
    out_status_nxt  = pend_status_r;
    out_holder_nxt  = ID_W'(pend_holder_r);
    out_live_nxt    = pend_live_r;
    out_last_nxt    = 1'b0;

    if (state_r == S_IDLE) begin
      cnt_nxt = '0;
    end

    if (emit_en && (32'(cnt_r) < MAX_RESULTS)) begin
      out_valid_nxt   = pend_v_r;
      pend_v_nxt      = 1'b1;
      pend_rcpt_nxt   = emit_rcpt;
      pend_status_nxt = emit_status;
      pend_holder_nxt = emit_holder;
      pend_live_nxt   = emit_live;
      cnt_nxt         = cnt_r + 1'b1;
    end

    if (state_r == S_DONE) begin
      out_valid_nxt = pend_v_r;
      out_last_nxt  = 1'b1;
      pend_v_nxt    = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      wvalid_r    <= '0;
      rdv_r       <= 1'b0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      wvalid_r    <= wvalid_nxt;
      rdv_r       <= rdv_nxt;
      found_r     <= found_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // indexes and payload
  always_ff @(posedge clk) begin
    q_r           <= q_nxt;
    lk_r          <= lk_nxt;
    i_r           <= i_nxt;
    j_r           <= j_nxt;
    jd_r          <= jd_nxt;
    w_r           <= w_nxt;
    v_r           <= v_nxt;
    pend_rcpt_r   <= pend_rcpt_nxt;
    pend_status_r <= pend_status_nxt;
    pend_holder_r <= pend_holder_nxt;
    pend_live_r   <= pend_live_nxt;
    out_rcpt_r    <= out_rcpt_nxt;
    out_status_r  <= out_status_nxt;
    out_holder_r  <= out_holder_nxt;
    out_live_r    <= out_live_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_recipient = out_rcpt_r;
  assign out_status    = out_status_r;
  assign out_holder    = out_holder_r;
  assign out_livelock  = out_live_r;
  assign out_last      = out_last_r;

endmodule

>>> test/testbench.sv
// self-checking testbench for lock_manager_deadlock_detect
// depends on lmdd_pkg and the lock manager rtl; predicts every reply internally
`timescale 1ns / 100ps

module testbench;
  import lmdd_pkg::*;

  localparam int CLIENTS     = CLIENTS_DEF;
  localparam int LOCKS       = LOCKS_DEF;
  localparam int RANDOM_WORDS = 75;
  // worst release: every lock passed on, one wait-table sweep each
  localparam int TAIL_CYCLES = LOCKS * (CLIENTS + 4) + 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [ID_W-1:0]     recipient;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     holder;
    logic                livelock;
    logic                last;
  } reply_t;

  // lock table predictor and reply queue
  class reply_board;
    bit              held [LOCKS];
    logic [ID_W-1:0] owner [LOCKS];
    bit              waiting [CLIENTS];
    logic [ID_W-1:0] wait_on [CLIENTS];
    logic [ID_W-1:0] wait_lock [CLIENTS];
    reply_t          replies_due [$];
    int              errors;

    function new();
      foreach (owner[i]) owner[i] = '0;
      errors = 0;
    endfunction

    function void add_reply(int rcpt, logic [STATUS_W-1:0] st, int hold, bit live, int base);
      reply_t r;
      if (replies_due.size() - base >= MAX_RESULTS) return;
      r.recipient = ID_W'(rcpt);
      r.status    = st;
      r.holder    = ID_W'(hold);
      r.livelock  = live;
      r.last      = 1'b0;
      replies_due.push_back(r);
    endfunction

    // any closed loop in the wait-for chains
    function bit cycle_in_waits();
      logic [CLIENTS-1:0] seen;
      int v;
      int steps;
      for (int s = 0; s < CLIENTS; s++) begin
        seen = '0;
        seen[s] = 1'b1;
        v = s;
        steps = 0;
        while (waiting[v] && steps <= CLIENTS) begin
          if (seen[wait_on[v]]) return 1'b1;
          seen[wait_on[v]] = 1'b1;
          v = wait_on[v];
          steps++;
        end
      end
      return 1'b0;
    endfunction

    // accepted word: update tables and queue the replies it causes
    function void note_word(logic act, logic [ID_W-1:0] req, logic [ID_W-1:0] lk);
      int base;
      int heir;
      bit full;
      reply_t r;
      // out-of-range requester, or out-of-range lock on a lock word, gives nothing
      if (int'(req) >= CLIENTS) return;
      if (act == ACT_LOCK && int'(lk) >= LOCKS) return;
      base = replies_due.size();
      if (act == ACT_RELEASE) begin
        for (int i = 0; i < LOCKS; i++) begin
          if (!held[i] || owner[i] != req) continue;
          heir = -1;
          for (int j = 0; j < CLIENTS; j++)
            if (heir < 0 && waiting[j] && wait_lock[j] == i) heir = j;
          if (heir < 0) begin
            held[i]  = 1'b0;
            owner[i] = '0;
          end else begin
            waiting[heir] = 1'b0;
            owner[i] = ID_W'(heir);
            for (int j = 0; j < CLIENTS; j++)
              if (waiting[j] && wait_lock[j] == i) wait_on[j] = ID_W'(heir);
            add_reply(heir, ST_GRANTED, 0, 1'b0, base);
          end
        end
      end else if (!held[lk]) begin
        held[lk]  = 1'b1;
        owner[lk] = req;
        add_reply(req, ST_GRANTED, 0, 1'b0, base);
      end else if (owner[lk] == req) begin
        add_reply(req, ST_OWN_IT, 0, 1'b0, base);
      end else begin
        waiting[req]   = 1'b1;
        wait_on[req]   = owner[lk];
        wait_lock[req] = lk;
        add_reply(req, ST_NOT_GRANTED, owner[lk], 1'b0, base);
        // a new edge that closes a loop is withdrawn
        if (cycle_in_waits()) begin
          waiting[req] = 1'b0;
          full = 1'b1;
          foreach (held[i]) if (!held[i]) full = 1'b0;
          add_reply(req, ST_PREVENTED, 0, full, base);
        end
      end
      if (replies_due.size() > base) begin
        r = replies_due.pop_back();
        r.last = 1'b1;
        replies_due.push_back(r);
      end
    endfunction

    function void compare_field(string field, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        $error("unexpected reply to client %0d with status %0d", got.recipient, got.status);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      compare_field("recipient", want.recipient, got.recipient);
      compare_field("status", ID_W'(want.status), ID_W'(got.status));
      compare_field("holder", want.holder, got.holder);
      compare_field("livelock", ID_W'(want.livelock), ID_W'(got.livelock));
      compare_field("last", ID_W'(want.last), ID_W'(got.last));
    endfunction
  endclass

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_action = ACT_LOCK;
  logic [ID_W-1:0]     in_requester = '0;
  logic [ID_W-1:0]     in_lock_id = '0;
  logic                out_valid;
  logic [ID_W-1:0]     out_recipient;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_holder;
  logic                out_livelock;
  logic                out_last;
  int                  cycles = 0;
  reply_board          board;

  lock_manager_deadlock_detect #(.CLIENTS(CLIENTS), .LOCKS(LOCKS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_requester (in_requester),
    .in_lock_id   (in_lock_id),
    .out_valid    (out_valid),
    .out_recipient(out_recipient),
    .out_status   (out_status),
    .out_holder   (out_holder),
    .out_livelock (out_livelock),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // present a word and hold it until the block takes it
  task automatic send_word(input logic act, input logic [ID_W-1:0] req,
                           input logic [ID_W-1:0] lk);
    start        <= 1'b1;
    in_action    <= act;
    in_requester <= req;
    in_lock_id   <= lk;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // sender gap with junk on the fields
  task automatic idle_for(input int n);
    start        <= 1'b0;
    in_action    <= 1'($urandom);
    in_requester <= ID_W'($urandom);
    in_lock_id   <= ID_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // observe accepted words and replies
  always @(posedge clk) begin
    if (rst_n && start && busy === 1'b0)
      board.note_word(in_action, in_requester, in_lock_id);
    if (rst_n && out_valid === 1'b1)
      board.check_reply('{out_recipient, out_status, out_holder, out_livelock, out_last});
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic            act;
    logic [ID_W-1:0] req;
    logic [ID_W-1:0] lk;
    int              sent;
    int              burst;
    bit              wide;

    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // grant, already own it, grant at top ids
    send_word(ACT_LOCK, 4'd0, 4'd0);
    send_word(ACT_LOCK, 4'd0, 4'd0);
    send_word(ACT_LOCK, 4'd15, 4'd15);
    // wait, then a two-client loop that gets prevented
    send_word(ACT_LOCK, 4'd15, 4'd0);
    send_word(ACT_LOCK, 4'd0, 4'd15);
    // release hands lock 0 to its waiter
    send_word(ACT_RELEASE, 4'd0, 4'd15);
    // fill every lock, then a loop with every lock held
    for (int i = 1; i < LOCKS - 1; i++) send_word(ACT_LOCK, ID_W'(i), ID_W'(i));
    send_word(ACT_LOCK, 4'd1, 4'd2);
    send_word(ACT_LOCK, 4'd2, 4'd1);
    // two waiters: lowest gets the lock, the other is redirected
    send_word(ACT_LOCK, 4'd5, 4'd15);
    send_word(ACT_LOCK, 4'd3, 4'd15);
    send_word(ACT_RELEASE, 4'd15, 4'd0);
    // release with nothing held
    send_word(ACT_RELEASE, 4'd0, 4'd10);

    // random bursts, mostly on a few contended clients and locks
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 8);
      for (int k = 0; k < burst; k++) begin
        wide = ($urandom_range(0, 3) == 0);
        req  = wide ? ID_W'($urandom_range(0, CLIENTS - 1)) : ID_W'($urandom_range(0, 4));
        lk   = wide ? ID_W'($urandom_range(0, LOCKS - 1)) : ID_W'($urandom_range(0, 4));
        act  = ($urandom_range(0, 9) < 3) ? ACT_RELEASE : ACT_LOCK;
        send_word(act, req, lk);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 12));
    end

    // drain replies, then watch for strays
    start <= 1'b0;
    @(posedge clk);
    while (board.replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
